// ===== design/levelled_exponential_eval_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the levelled exponential evaluator
// Clocked, reset-qualified property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef LEVELLED_EXPONENTIAL_EVAL_TOP_ASSERT_SVH
`define LEVELLED_EXPONENTIAL_EVAL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LEE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lee_pkg.sv =====
// ----------------------------------------------------------------------------
// Levelled exponential evaluator package
// Shared types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package lee_pkg;

  localparam int DataW   = 32;
  localparam int AngW    = 19;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_SLOPE  = 3'd1,
    REG_QUAD   = 3'd2,
    REG_CENTRE = 3'd3,
    REG_ANGLE  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_e;

  // CORDIC constants, angles in Q2.16 and vectors in Q30.
  localparam int CordicSteps = 16;
  localparam int HalfPi      = 102944;
  localparam int PiQ16       = 205887;
  localparam int CordicGain  = 652032874;
  localparam logic [15:0] ATAN_Q16 [CordicSteps] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  // Exponential constants.
  localparam longint LnTwoQ30 = 744261118;
  localparam logic [24:0] LnRecip = 25'((64'd1 << 54) / 64'(LnTwoQ30));
  localparam int QuotW       = 36;
  localparam int TaylorTerms = 13;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
  } lee_in_t;

  typedef struct packed {
    logic [DataW-1:0] shape_value;
    status_e          status;
  } lee_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rot_stat_t;

  // Denominator beat handed from the front end to the exponential back end.
  typedef struct packed {
    logic        zero;
    logic        grow;
    logic [62:0] ad;
    logic [32:0] t;
  } den_beat_t;

endpackage

// ===== design/lee_sample_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one sample per beat.
// ----------------------------------------------------------------------------
interface lee_sample_if;
  logic            valid;
  logic            ready;
  lee_pkg::lee_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lee_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one shape value and status per beat.
// ----------------------------------------------------------------------------
interface lee_result_if;
  logic              valid;
  logic              ready;
  lee_pkg::lee_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lee_rot.sv =====
// ----------------------------------------------------------------------------
// Coefficient rotation
// Iterative CORDIC for sin/cos of theta, then turns (sigma, alpha) into (s, a).
// ----------------------------------------------------------------------------
module lee_rot (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [lee_pkg::DataW-1:0]   sigma_i,
  input  logic signed [lee_pkg::DataW-1:0]   alpha_i,
  input  logic signed [lee_pkg::AngW-1:0]    theta_i,
  output logic signed [lee_pkg::DataW-1:0]   s_o,
  output logic signed [lee_pkg::DataW-1:0]   a_o,
  output lee_pkg::rot_stat_t                 stat_o
);
  import lee_pkg::*;

  typedef enum logic [4:0] {
    R_IDLE = 5'b00001,
    R_LOAD = 5'b00010,
    R_TURN = 5'b00100,
    R_MUL  = 5'b01000,
    R_SUM  = 5'b10000
  } rot_state_e;

  localparam logic signed [65:0] RndQ30 = 66'sd1 <<< 29;

  rot_state_e state_q, state_d;
  logic signed [32:0] x_q, x_d, y_q, y_d, dx, dy, cx, sx;
  logic signed [19:0] z_q, z_d, ang, at;
  logic [3:0]         i_q, i_d;
  logic               neg_q, neg_d;
  logic signed [64:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [65:0] sd, ad;
  logic signed [DataW-1:0] s_q, a_q;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = (v + RndQ30) >>> 30;
    if (r > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[DataW-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    neg_d   = neg_q;
    ang     = {theta_i[AngW-1], theta_i};
    dx      = y_q >>> i_q;
    dy      = x_q >>> i_q;
    at      = signed'(20'(ATAN_Q16[i_q]));
    unique case (state_q)
      R_IDLE: ;
      R_LOAD: begin
        neg_d = 1'b0;
        if (ang > 20'(HalfPi)) begin
          ang   = ang - 20'(PiQ16);
          neg_d = 1'b1;
        end else if (ang < -20'(HalfPi)) begin
          ang   = ang + 20'(PiQ16);
          neg_d = 1'b1;
        end
        x_d     = 33'(CordicGain);
        y_d     = '0;
        z_d     = ang;
        i_d     = '0;
        state_d = R_TURN;
      end
      R_TURN: begin
        if (z_q >= 0) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        i_d = i_q + 4'd1;
        if (i_q == 4'(CordicSteps - 1)) begin
          state_d = R_MUL;
        end
      end
      R_MUL:   state_d = R_SUM;
      R_SUM:   state_d = R_IDLE;
      default: state_d = R_LOAD;
    endcase
    if (start_i) begin
      state_d = R_LOAD;
    end
  end

  assign cx = neg_q ? -x_q : x_q;
  assign sx = neg_q ? -y_q : y_q;
  assign sd = 66'(p0_q) - 66'(p1_q);
  assign ad = 66'(p2_q) + 66'(p3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    i_q   <= i_d;
    neg_q <= neg_d;
    if (state_q == R_MUL) begin
      p0_q <= 65'(cx) * 65'(sigma_i);
      p1_q <= 65'(sx) * 65'(alpha_i);
      p2_q <= 65'(sx) * 65'(sigma_i);
      p3_q <= 65'(cx) * 65'(alpha_i);
    end
    if (state_q == R_SUM) begin
      s_q <= sat32(sd);
      a_q <= sat32(ad);
    end
  end

  assign s_o         = s_q;
  assign a_o         = a_q;
  assign stat_o.busy = (state_q != R_IDLE);
  assign stat_o.done = (state_q == R_SUM);

endmodule

// ===== design/lee_exp.sv =====
// ----------------------------------------------------------------------------
// Ratio and exponential back end
// Bit-per-stage divider for t/|den|, base-2 range reduction, a pipelined
// Taylor series and the final scaling into the output register.
// ----------------------------------------------------------------------------
module lee_exp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  lee_pkg::den_beat_t beat_i,
  output logic               valid_o,
  output lee_pkg::lee_out_t  res_o
);
  import lee_pkg::*;

  localparam logic [QuotW-1:0] QMax = QuotW'(64'd32 << 30);

  typedef struct packed {
    logic [62:0]      n;
    logic [62:0]      ad;
    logic [63:0]      r;
    logic [QuotW-1:0] q;
    logic             ovf;
    logic             zero;
    logic             grow;
  } div_t;

  typedef struct packed {
    logic [30:0]       term;
    logic [63:0]       pm;
    logic [31:0]       sum;
    logic [29:0]       r;
    logic signed [7:0] k;
    logic              zero;
  } tay_t;

  // Divider
  div_t        dv_q [QuotW+1];
  logic [QuotW:0] dvv_q;
  logic [62:0] n0;

  // Range reduction
  logic             cv_q, e1v_q, e2v_q, e3v_q;
  logic [QuotW-1:0] c_q, e1q_q, e2q_q;
  logic             cz_q, cg_q, e1z_q, e1g_q, e2z_q, e2g_q, e3z_q, e3g_q;
  logic [44:0]      e1pm_q;
  logic [6:0]       e2k_q, e3k_q, ke3;
  logic [36:0]      e2kl_q, rem3;
  logic [29:0]      e3r_q;

  // Series
  tay_t ta_q [1:TaylorTerms];
  tay_t tb_q [1:TaylorTerms];
  tay_t tc_q [0:TaylorTerms];
  logic [TaylorTerms:1] tav_q, tbv_q;
  logic [TaylorTerms:0] tcv_q;

  // Output
  logic              ov_q;
  lee_out_t          res_q, res_d;
  logic signed [8:0] sh;
  logic [63:0]       wide;

  // -------- divider entry --------
  assign n0 = {beat_i.t, 30'b0} + 63'(beat_i.ad >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (adv_i) begin
      dvv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dv_q[0].n    <= n0;
      dv_q[0].ad   <= beat_i.ad;
      dv_q[0].r    <= 64'(n0[62:QuotW]);
      dv_q[0].q    <= '0;
      dv_q[0].ovf  <= 63'(n0[62:QuotW]) >= beat_i.ad;
      dv_q[0].zero <= beat_i.zero;
      dv_q[0].grow <= beat_i.grow;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    localparam int Bit = QuotW - 1 - k;
    div_t nx;
    always_comb begin
      nx   = dv_q[k];
      nx.r = {dv_q[k].r[62:0], dv_q[k].n[Bit]};
      if (nx.r >= {1'b0, dv_q[k].ad}) begin
        nx.r      = nx.r - {1'b0, dv_q[k].ad};
        nx.q[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        dvv_q[k+1] <= dvv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dv_q[k+1] <= nx;
      end
    end
  end

  // -------- clamp, reciprocal estimate, correction --------
  always_comb begin
    rem3 = 37'(e2q_q) - e2kl_q;
    ke3  = e2k_q;
    if (rem3 >= 37'(LnTwoQ30)) begin
      rem3 = rem3 - 37'(LnTwoQ30);
      ke3  = ke3 + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q  <= 1'b0;
      e1v_q <= 1'b0;
      e2v_q <= 1'b0;
      e3v_q <= 1'b0;
    end else if (adv_i) begin
      cv_q  <= dvv_q[QuotW];
      e1v_q <= cv_q;
      e2v_q <= e1v_q;
      e3v_q <= e2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q    <= (dv_q[QuotW].ovf || dv_q[QuotW].q > QMax) ? QMax : dv_q[QuotW].q;
      cz_q   <= dv_q[QuotW].zero;
      cg_q   <= dv_q[QuotW].grow;
      e1pm_q <= 45'(c_q[QuotW-1:16]) * 45'(LnRecip);
      e1q_q  <= c_q;
      e1z_q  <= cz_q;
      e1g_q  <= cg_q;
      e2k_q  <= e1pm_q[44:38];
      e2kl_q <= 37'(e1pm_q[44:38]) * 37'(LnTwoQ30);
      e2q_q  <= e1q_q;
      e2z_q  <= e1z_q;
      e2g_q  <= e1g_q;
      e3k_q  <= ke3;
      e3r_q  <= rem3[29:0];
      e3z_q  <= e2z_q;
      e3g_q  <= e2g_q;
    end
  end

  // -------- series seed: signed k and remainder r in [0, ln2) --------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcv_q[0] <= 1'b0;
    end else if (adv_i) begin
      tcv_q[0] <= e3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tc_q[0].term <= 31'(1) << 30;
      tc_q[0].sum  <= 32'(1) << 30;
      tc_q[0].pm   <= '0;
      tc_q[0].zero <= e3z_q;
      if (e3g_q || e3r_q == '0) begin
        tc_q[0].r <= e3r_q;
        tc_q[0].k <= e3g_q ? signed'({1'b0, e3k_q}) : -signed'({1'b0, e3k_q});
      end else begin
        tc_q[0].r <= 30'(LnTwoQ30) - e3r_q;
        tc_q[0].k <= -(signed'({1'b0, e3k_q}) + 8'sd1);
      end
    end
  end

  // -------- Taylor terms: multiply, reciprocal, correct and accumulate --------
  for (genvar n = 1; n <= TaylorTerms; n++) begin : g_tay
    localparam logic [32:0] RecipN = 33'((64'd1 << 32) / 64'(n));
    logic [60:0] prod;
    logic [31:0] qe;
    logic [39:0] nxt, qf;
    tay_t        na, nb, nc;

    assign prod = 61'(tc_q[n-1].term) * 61'(tc_q[n-1].r);

    always_comb begin
      na      = tc_q[n-1];
      na.term = prod[60:30];
      nb      = ta_q[n];
      nb.pm   = 64'(ta_q[n].term) * 64'(RecipN);
    end

    always_comb begin
      nc  = tb_q[n];
      qe  = tb_q[n].pm[63:32];
      nxt = 40'(qe) + 40'd1;
      qf  = 40'(qe);
      if (40'(tb_q[n].term) >= nxt * 40'(n)) begin
        qf = nxt;
      end
      nc.term = qf[30:0];
      nc.sum  = tb_q[n].sum + 32'(qf[30:0]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tav_q[n] <= 1'b0;
        tbv_q[n] <= 1'b0;
        tcv_q[n] <= 1'b0;
      end else if (adv_i) begin
        tav_q[n] <= tcv_q[n-1];
        tbv_q[n] <= tav_q[n];
        tcv_q[n] <= tbv_q[n];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ta_q[n] <= na;
        tb_q[n] <= nb;
        tc_q[n] <= nc;
      end
    end
  end

  // -------- final scaling by 2^k into FRAC_BITS fraction bits --------
  always_comb begin
    sh    = 9'(30 - FRAC_BITS) - {tc_q[TaylorTerms].k[7], tc_q[TaylorTerms].k};
    wide  = '0;
    res_d.shape_value = '0;
    res_d.status      = STATUS_OK;
    if (tc_q[TaylorTerms].zero) begin
      res_d.status = STATUS_ZERO;
    end else if (sh > 9'sd0) begin
      if (sh < 9'sd62) begin
        wide = (64'(tc_q[TaylorTerms].sum) + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
        res_d.shape_value = wide[DataW-1:0];
      end
    end else if (sh < -9'sd32) begin
      res_d.shape_value = '1;
      res_d.status      = STATUS_SAT;
    end else begin
      wide = 64'(tc_q[TaylorTerms].sum) << 6'(-sh);
      if (wide[63:DataW] != '0) begin
        res_d.shape_value = '1;
        res_d.status      = STATUS_SAT;
      end else begin
        res_d.shape_value = wide[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv_i) begin
      ov_q <= tcv_q[TaylorTerms];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = ov_q;
  assign res_o   = res_q;

endmodule

// ===== design/levelled_exponential_eval_top.sv =====
// ----------------------------------------------------------------------------
// Levelled exponential evaluator
// Samples pass the front end, divider, range reduction and Taylor series into
// the output register. Throughput: one sample per cycle; the whole pipeline
// holds while the result beat waits, so stalls lose nothing. After reset and
// after every register write the coefficient CORDIC runs with the sample
// ready low. Reset is asynchronous and active low; registers take defaults.
// ----------------------------------------------------------------------------
module levelled_exponential_eval_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lee_sample_if.sink                    sample_i,
  lee_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [lee_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lee_pkg::DataW-1:0]     cfg_data_i
);
  import lee_pkg::*;

  // Product width for a*t and t*t, and the split of the rounded square
  // into an integer part (hi) and a fraction part (lo).
  localparam int PW   = 66;
  localparam int T2W  = PW - FRAC_BITS;
  localparam int HiW  = PW - 2 * FRAC_BITS;
  localparam int MhW  = DataW + 1 + HiW;
  localparam int BlW  = DataW + 1 + FRAC_BITS;
  localparam int CmpW = (MhW > 64) ? MhW : 64;

  localparam logic signed [PW-1:0]  RndS  = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic [PW-1:0]         RndU  = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [BlW-1:0] RndB  = BlW'(1) <<< (FRAC_BITS - 1);
  localparam logic [CmpW-1:0]       LimU  = CmpW'(1) << 62;
  localparam logic signed [66:0]    LimS  = 67'sd1 <<< 62;

  // Configuration registers.
  logic signed [DataW-1:0] width_q, slope_q, quad_q, centre_q;
  logic signed [AngW-1:0]  angle_q;

  // Rotated coefficients from the CORDIC sequencer.
  logic signed [DataW-1:0] rot_s, rot_a;
  rot_stat_t               rot_stat;

  // Pipeline control: every stage moves when the output register is free.
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic exp_valid;
  lee_out_t exp_res;

  // Stage payloads.
  logic signed [32:0]     diff;
  logic [32:0]            t1_d, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q;
  logic signed [PW-1:0]   at_q, lin_d, lin3_q, lin4_q, lin5_q;
  logic [PW-1:0]          tt_q;
  logic [T2W-1:0]         sq_d;
  logic [HiW-1:0]         hi_q;
  logic [FRAC_BITS-1:0]   lo_q;
  logic [DataW:0]         mag;
  logic [MhW-1:0]         mh_q;
  logic signed [BlW-1:0]  bl_q, rb;
  logic [CmpW-1:0]        mhw;
  logic signed [66:0]     sqh, quad_sum, den_sum_d, den_sum_q, den;
  logic signed [63:0]     quad5_q;
  den_beat_t              beat_d, beat_q;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DataW'(1) << FRAC_BITS;
      slope_q  <= '0;
      quad_q   <= '0;
      centre_q <= '0;
      angle_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_SLOPE:  slope_q  <= cfg_data_i;
        REG_QUAD:   quad_q   <= cfg_data_i;
        REG_CENTRE: centre_q <= cfg_data_i;
        REG_ANGLE:  angle_q  <= cfg_data_i[AngW-1:0];
        default: ;
      endcase
    end
  end

  // Any write restarts the rotation so s and a always follow the registers.
  lee_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .sigma_i (width_q),
    .alpha_i (slope_q),
    .theta_i (angle_q),
    .s_o     (rot_s),
    .a_o     (rot_a),
    .stat_o  (rot_stat)
  );

  // ---------------- handshake ----------------
  // The output register is the last stage; a beat in it that is not taken
  // freezes the pipeline, otherwise all stages shift together.
  assign adv            = !exp_valid || result_o.ready;
  assign sample_i.ready = adv && !rot_stat.busy;
  assign result_o.valid = exp_valid;
  assign result_o.data  = exp_res;

  // ---------------- front end datapath ----------------
  // Stage 1: distance from the centre, t = |x - m|.
  assign diff = {sample_i.data.sample[DataW-1], sample_i.data.sample}
              - {centre_q[DataW-1], centre_q};
  assign t1_d = diff[32] ? 33'(-diff) : 33'(diff);

  // Stage 3: round a*t and t*t back to FRAC_BITS fraction bits.
  assign lin_d = (at_q + RndS) >>> FRAC_BITS;
  assign sq_d  = T2W'((tt_q + RndU) >> FRAC_BITS);

  // Stage 4: |beta| times the integer part of t*t; beta times the fraction.
  assign mag = quad_q[DataW-1] ? (DataW+1)'(-quad_q) : (DataW+1)'(quad_q);

  // Stage 5: clamp the integer product, restore the sign and add the
  // rounded fraction product; the quadratic term stays within +-2^62.
  assign mhw = CmpW'(mh_q);
  assign rb  = (bl_q + RndB) >>> FRAC_BITS;

  always_comb begin
    sqh = (mhw > LimU) ? LimS : 67'(signed'({1'b0, mhw[62:0]}));
    if (quad_q[DataW-1]) begin
      sqh = -sqh;
    end
    quad_sum = sqh + 67'(rb);
    if (quad_sum > LimS) begin
      quad_sum = LimS;
    end else if (quad_sum < -LimS) begin
      quad_sum = -LimS;
    end
  end

  // Stage 6: den = s + a*t + beta*t*t.
  assign den_sum_d = 67'(rot_s) + 67'(lin5_q) + 67'(quad5_q);

  // Stage 7: clamp den and split it into magnitude, sign and a zero flag.
  always_comb begin
    den = den_sum_q;
    if (den > LimS) begin
      den = LimS;
    end else if (den < -LimS) begin
      den = -LimS;
    end
    beat_d.zero = (den == '0);
    beat_d.grow = den[66];
    beat_d.ad   = den[66] ? 63'(-den) : 63'(den);
    beat_d.t    = t6_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v1_q <= sample_i.valid && sample_i.ready;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q      <= t1_d;
      at_q      <= PW'(rot_a) * PW'(signed'({1'b0, t1_q}));
      tt_q      <= PW'(t1_q) * PW'(t1_q);
      t2_q      <= t1_q;
      lin3_q    <= lin_d;
      hi_q      <= sq_d[T2W-1:FRAC_BITS];
      lo_q      <= sq_d[FRAC_BITS-1:0];
      t3_q      <= t2_q;
      mh_q      <= MhW'(mag) * MhW'(hi_q);
      bl_q      <= BlW'(quad_q) * BlW'(signed'({1'b0, lo_q}));
      lin4_q    <= lin3_q;
      t4_q      <= t3_q;
      quad5_q   <= quad_sum[63:0];
      lin5_q    <= lin4_q;
      t5_q      <= t4_q;
      den_sum_q <= den_sum_d;
      t6_q      <= t5_q;
      beat_q    <= beat_d;
    end
  end

  // ---------------- ratio and exponential ----------------
  lee_exp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v7_q),
    .beat_i  (beat_q),
    .valid_o (exp_valid),
    .res_o   (exp_res)
  );

endmodule

// ===== design/lee_chk.sv =====
// ----------------------------------------------------------------------------
// Port checker for the levelled exponential evaluator
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module lee_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lee_pkg::DataW-1:0] out_value,
  input logic [1:0]                out_status,
  input logic                      cfg_we
);
  import lee_pkg::*;
  `include "levelled_exponential_eval_top_assert.svh"

  // A result beat that is not taken stays offered.
  `LEE_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result beat dropped")

  // A zero denominator always comes with a zero shape value.
  `LEE_ASSERT_NOW(a_zero_value, out_valid && out_status == STATUS_ZERO, out_value == '0, "zero status with nonzero value")

  // Saturation always reports the largest code.
  `LEE_ASSERT_NOW(a_sat_value, out_valid && out_status == STATUS_SAT, out_value == '1, "saturated status without full scale")

  // A register write restarts the rotation, so no sample is taken next cycle.
  `LEE_ASSERT_NEXT(a_cfg_busy, cfg_we, !in_ready, "sample ready right after register write")

endmodule

bind levelled_exponential_eval_top lee_chk u_lee_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (sample_i.ready),
  .out_valid  (result_o.valid),
  .out_ready  (result_o.ready),
  .out_value  (result_o.data.shape_value),
  .out_status (result_o.data.status),
  .cfg_we     (cfg_we_i)
);
